>>> rtl/cspmv_pkg.sv
// Shared types, constants and helpers for the CSR sparse matrix-vector block.
// No dependencies; imported by every module under rtl/.
package cspmv_pkg;

  localparam int unsigned     VEC_DEPTH_DEF = 1024;
  localparam longint unsigned MAX_ROWS_DEF  = 64'd65536;

  localparam int IDX_W = 10;
  localparam int DW    = 64;
  localparam int ROW_W = 16;

  localparam logic [DW-1:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_NZ    = 2'd1,
    OP_EMPTY = 2'd2
  } op_t;

  typedef struct packed {
    logic          vld;
    op_t           op;
    logic          last;
    logic [DW-1:0] prod;
  } mul_tail_t;

  function automatic logic is_nan(input logic [DW-1:0] b);
    return (&b[62:52]) && (|b[51:0]);
  endfunction

  function automatic logic is_inf(input logic [DW-1:0] b);
    return (&b[62:52]) && !(|b[51:0]);
  endfunction

endpackage

>>> rtl/cspmv_mul.sv
// Front end: vector store (registered-read memory) and pipelined binary64 multiplier.
// Depends on cspmv_pkg. All stages advance together on en.
module cspmv_mul #(
  parameter int unsigned VEC_DEPTH = cspmv_pkg::VEC_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [1:0]                  in_op,
  input  logic [cspmv_pkg::IDX_W-1:0] in_index,
  input  logic [cspmv_pkg::DW-1:0]    in_value,
  input  logic                        in_row_last,
  output cspmv_pkg::mul_tail_t        tail
);
  import cspmv_pkg::*;

  localparam int AW = $clog2(VEC_DEPTH);

  function automatic logic [6:0] lzc106(input logic [105:0] v);
    logic [6:0] n;
    n = 7'd106;
    for (int i = 0; i < 106; i++) begin
      if (v[i]) n = 7'(105 - i);
    end
    return n;
  endfunction

  logic [DW-1:0] mem [VEC_DEPTH];
  logic          in_range;
  logic [AW-1:0] addr;
  op_t           op_in;

  assign op_in    = op_t'(in_op);
  assign in_range = 32'(in_index) < 32'(VEC_DEPTH);
  assign addr     = AW'(in_index);

  always_ff @(posedge clk) begin
    if (en && in_valid && op_in == OP_LOAD && in_range) begin
      mem[addr] <= in_value;
    end
  end

  // stage 1: operands
  logic          s1_v_r;
  op_t           s1_op_r;
  logic          s1_last_r, s1_ok_r;
  logic [DW-1:0] s1_a_r, mem_q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mem_q_r   <= mem[addr];
      s1_op_r   <= op_in;
      s1_last_r <= in_row_last;
      s1_ok_r   <= in_range;
      s1_a_r    <= in_value;
    end
  end

  // stage 2: unpack, partial products
  logic [DW-1:0]      xb;
  logic [52:0]        ma, mb;
  logic [10:0]        ea, eb;
  logic [51:0]        hh_c;
  logic [52:0]        hl_c, lh_c;
  logic [53:0]        ll_c;
  logic signed [12:0] eu_c;
  logic               nan_c, inf_c, zero_c;
  logic [DW-1:0]      specv_c;

  assign xb   = s1_ok_r ? mem_q_r : '0;
  assign ma   = {|s1_a_r[62:52], s1_a_r[51:0]};
  assign mb   = {|xb[62:52], xb[51:0]};
  assign ea   = (s1_a_r[62:52] == 11'd0) ? 11'd1 : s1_a_r[62:52];
  assign eb   = (xb[62:52] == 11'd0) ? 11'd1 : xb[62:52];
  assign eu_c = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 13'sd1022;
  assign hh_c = ma[52:27] * mb[52:27];
  assign hl_c = ma[52:27] * mb[26:0];
  assign lh_c = ma[26:0] * mb[52:27];
  assign ll_c = ma[26:0] * mb[26:0];

  always_comb begin
    zero_c  = (s1_a_r[62:0] == 63'd0) || (xb[62:0] == 63'd0);
    inf_c   = is_inf(s1_a_r) || is_inf(xb);
    nan_c   = is_nan(s1_a_r) || is_nan(xb) || (inf_c && zero_c);
    if (nan_c) begin
      specv_c = CANON_NAN;
    end else if (inf_c) begin
      specv_c = {s1_a_r[63] ^ xb[63], 11'h7FF, 52'd0};
    end else begin
      specv_c = {s1_a_r[63] ^ xb[63], 63'd0};
    end
  end

  logic               s2_v_r, s2_last_r, s2_sign_r, s2_spec_r;
  op_t                s2_op_r;
  logic [51:0]        s2_hh_r;
  logic [52:0]        s2_hl_r, s2_lh_r;
  logic [53:0]        s2_ll_r;
  logic signed [12:0] s2_eu_r;
  logic [DW-1:0]      s2_specv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op_r    <= s1_op_r;
      s2_last_r  <= s1_last_r;
      s2_hh_r    <= hh_c;
      s2_hl_r    <= hl_c;
      s2_lh_r    <= lh_c;
      s2_ll_r    <= ll_c;
      s2_eu_r    <= eu_c;
      s2_sign_r  <= s1_a_r[63] ^ xb[63];
      s2_spec_r  <= nan_c || inf_c || zero_c;
      s2_specv_r <= specv_c;
    end
  end

  // stage 3: sum partial products
  logic [105:0]       p_c;
  assign p_c = (106'(s2_hh_r) << 54) + (106'(s2_hl_r) << 27) + (106'(s2_lh_r) << 27)
             + 106'(s2_ll_r);

  logic               s3_v_r, s3_last_r, s3_sign_r, s3_spec_r;
  op_t                s3_op_r;
  logic [105:0]       s3_p_r;
  logic signed [12:0] s3_eu_r;
  logic [DW-1:0]      s3_specv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_op_r    <= s2_op_r;
      s3_last_r  <= s2_last_r;
      s3_p_r     <= p_c;
      s3_eu_r    <= s2_eu_r;
      s3_sign_r  <= s2_sign_r;
      s3_spec_r  <= s2_spec_r;
      s3_specv_r <= s2_specv_r;
    end
  end

  // stage 4: leading zero count, shift plan
  logic [6:0]         lz;
  logic signed [12:0] en_c;
  logic               left_c;
  logic [6:0]         amt_c;
  logic [11:0]        ef_c;

  assign lz   = lzc106(s3_p_r);
  assign en_c = s3_eu_r - $signed({6'd0, lz});

  always_comb begin
    if (en_c >= 13'sd1) begin
      left_c = 1'b1;
      amt_c  = lz;
      ef_c   = 12'(en_c);
    end else if (s3_eu_r >= 13'sd1) begin
      left_c = 1'b1;
      amt_c  = 7'(s3_eu_r - 13'sd1);
      ef_c   = '0;
    end else begin
      left_c = 1'b0;
      amt_c  = (s3_eu_r < -13'sd120) ? 7'd127 : 7'(13'sd1 - s3_eu_r);
      ef_c   = '0;
    end
  end

  logic          s4_v_r, s4_last_r, s4_sign_r, s4_spec_r, s4_left_r;
  op_t           s4_op_r;
  logic [105:0]  s4_p_r;
  logic [6:0]    s4_amt_r;
  logic [11:0]   s4_ef_r;
  logic [DW-1:0] s4_specv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_op_r    <= s3_op_r;
      s4_last_r  <= s3_last_r;
      s4_p_r     <= s3_p_r;
      s4_amt_r   <= amt_c;
      s4_left_r  <= left_c;
      s4_ef_r    <= ef_c;
      s4_sign_r  <= s3_sign_r;
      s4_spec_r  <= s3_spec_r;
      s4_specv_r <= s3_specv_r;
    end
  end

  // stage 5: normalize
  logic [105:0] shr_c, n_c;
  logic         lost_c;

  assign shr_c  = s4_p_r >> s4_amt_r;
  assign lost_c = !s4_left_r && ((shr_c << s4_amt_r) != s4_p_r);
  assign n_c    = s4_left_r ? (s4_p_r << s4_amt_r) : shr_c;

  logic          s5_v_r, s5_last_r, s5_sign_r, s5_spec_r, s5_lost_r;
  op_t           s5_op_r;
  logic [105:0]  s5_n_r;
  logic [11:0]   s5_ef_r;
  logic [DW-1:0] s5_specv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_op_r    <= s4_op_r;
      s5_last_r  <= s4_last_r;
      s5_n_r     <= n_c;
      s5_lost_r  <= lost_c;
      s5_ef_r    <= s4_ef_r;
      s5_sign_r  <= s4_sign_r;
      s5_spec_r  <= s4_spec_r;
      s5_specv_r <= s4_specv_r;
    end
  end

  // stage 6: round to nearest even, pack
  logic          rnd_c;
  logic [62:0]   mag_c;
  logic [DW-1:0] prod_c;

  assign rnd_c = s5_n_r[52] && ((|s5_n_r[51:0]) || s5_lost_r || s5_n_r[53]);
  assign mag_c = {s5_ef_r[10:0], s5_n_r[104:53]} + 63'(rnd_c);

  always_comb begin
    if (s5_spec_r) begin
      prod_c = s5_specv_r;
    end else if (s5_ef_r >= 12'd2047) begin
      prod_c = {s5_sign_r, 11'h7FF, 52'd0};
    end else begin
      prod_c = {s5_sign_r, mag_c};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail.op   <= s5_op_r;
      tail.last <= s5_last_r;
      tail.prod <= prod_c;
    end
    if (!rst_n) begin
      tail.vld <= 1'b0;
    end else if (en) begin
      tail.vld <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      s4_v_r   <= 1'b0;
      s5_v_r   <= 1'b0;
    end else if (en) begin
      s1_v_r   <= in_valid && (op_in == OP_NZ || op_in == OP_EMPTY);
      s2_v_r   <= s1_v_r;
      s3_v_r   <= s2_v_r;
      s4_v_r   <= s3_v_r;
      s5_v_r   <= s4_v_r;
    end
  end

endmodule

>>> rtl/cspmv_add.sv
// Pipelined binary64 adder, result held until acked; the caller must keep at most
// one operation in flight, which the block leaves to it. Depends on cspmv_pkg.
module cspmv_add (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [cspmv_pkg::DW-1:0] a,
  input  logic [cspmv_pkg::DW-1:0] b,
  input  logic                     ack,
  output logic                     busy,
  output logic                     res_valid,
  output logic [cspmv_pkg::DW-1:0] res
);
  import cspmv_pkg::*;

  function automatic logic [5:0] lzc57(input logic [56:0] v);
    logic [5:0] n;
    n = 6'd57;
    for (int i = 0; i < 57; i++) begin
      if (v[i]) n = 6'(56 - i);
    end
    return n;
  endfunction

  // phase 1: order by magnitude, unpack
  logic          swap;
  logic [DW-1:0] x, y, specv_c;
  logic [10:0]   xe, ye, d;
  logic          nan_c;

  assign swap = b[62:0] > a[62:0];
  assign x    = swap ? b : a;
  assign y    = swap ? a : b;
  assign xe   = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
  assign ye   = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
  assign d    = xe - ye;
  assign nan_c = is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[63] ^ b[63]));
  assign specv_c = nan_c ? CANON_NAN : x;

  logic          p1_v_r, p1_sx_r, p1_sub_r, p1_zs_r, p1_spec_r;
  logic [52:0]   p1_xm_r, p1_ym_r;
  logic [10:0]   p1_xe_r;
  logic [5:0]    p1_d_r;
  logic [DW-1:0] p1_specv_r;

  always_ff @(posedge clk) begin
    if (start) begin
      p1_xm_r    <= {|x[62:52], x[51:0]};
      p1_ym_r    <= {|y[62:52], y[51:0]};
      p1_xe_r    <= xe;
      p1_d_r     <= (d > 11'd63) ? 6'd63 : d[5:0];
      p1_sx_r    <= x[63];
      p1_sub_r   <= a[63] ^ b[63];
      p1_zs_r    <= a[63] & b[63];
      p1_spec_r  <= nan_c || is_inf(x);
      p1_specv_r <= specv_c;
    end
  end

  // phase 2: align, add or subtract
  logic [55:0] yf, ysh, ya, xf;
  logic        lost;
  logic [56:0] z_c;

  assign xf   = {p1_xm_r, 3'b000};
  assign yf   = {p1_ym_r, 3'b000};
  assign ysh  = yf >> p1_d_r;
  assign lost = (ysh << p1_d_r) != yf;
  assign ya   = {ysh[55:1], ysh[0] | lost};
  assign z_c  = p1_sub_r ? ({1'b0, xf} - {1'b0, ya}) : ({1'b0, xf} + {1'b0, ya});

  logic          p2_v_r, p2_sx_r, p2_zs_r, p2_spec_r;
  logic [56:0]   p2_z_r;
  logic [10:0]   p2_xe_r;
  logic [DW-1:0] p2_specv_r;

  always_ff @(posedge clk) begin
    p2_z_r     <= z_c;
    p2_xe_r    <= p1_xe_r;
    p2_sx_r    <= p1_sx_r;
    p2_zs_r    <= p1_zs_r;
    p2_spec_r  <= p1_spec_r;
    p2_specv_r <= p1_specv_r;
  end

  // phase 3: normalize
  logic [5:0]         lz, sh;
  logic signed [12:0] en_c;
  logic [11:0]        ef_c;

  assign lz   = lzc57(p2_z_r);
  assign en_c = $signed({2'b00, p2_xe_r}) + 13'sd1 - $signed({7'd0, lz});

  always_comb begin
    if (en_c >= 13'sd1) begin
      sh   = lz;
      ef_c = 12'(en_c);
    end else begin
      sh   = 6'(p2_xe_r);
      ef_c = '0;
    end
  end

  logic          p3_v_r, p3_sx_r, p3_zs_r, p3_zero_r, p3_spec_r;
  logic [56:0]   p3_n_r;
  logic [11:0]   p3_ef_r;
  logic [DW-1:0] p3_specv_r;

  always_ff @(posedge clk) begin
    p3_n_r     <= p2_z_r << sh;
    p3_ef_r    <= ef_c;
    p3_sx_r    <= p2_sx_r;
    p3_zs_r    <= p2_zs_r;
    p3_zero_r  <= p2_z_r == 57'd0;
    p3_spec_r  <= p2_spec_r;
    p3_specv_r <= p2_specv_r;
  end

  // phase 4: round, pack
  logic          rnd;
  logic [62:0]   mag;
  logic [DW-1:0] res_c;

  assign rnd = p3_n_r[3] && ((|p3_n_r[2:0]) || p3_n_r[4]);
  assign mag = {p3_ef_r[10:0], p3_n_r[55:4]} + 63'(rnd);

  always_comb begin
    if (p3_spec_r) begin
      res_c = p3_specv_r;
    end else if (p3_zero_r) begin
      res_c = {p3_zs_r, 63'd0};
    end else if (p3_ef_r >= 12'd2047) begin
      res_c = {p3_sx_r, 11'h7FF, 52'd0};
    end else begin
      res_c = {p3_sx_r, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (p3_v_r) begin
      res <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
      p3_v_r    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      p1_v_r <= start;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      if (p3_v_r) begin
        res_valid <= 1'b1;
      end else if (ack) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign busy = p1_v_r || p2_v_r || p3_v_r || res_valid;

endmodule

>>> rtl/csr_sparse_matrix_vector_multiply_top.sv
// Top level: CSR sparse matrix times dense vector in binary64.
// Depends on cspmv_pkg, cspmv_mul and cspmv_add.
//
// Input channel (in_*): one beat per item. op LOAD writes in_value into the
// vector store at in_index; op NZ multiplies in_value by the stored entry at
// column in_index and adds the product to the row sum; op EMPTY reports a
// zero row. Result channel (out_*): one beat per finished row, carrying the
// row number and the sum, in item order.
// A LOAD is taken whenever the multiplier pipeline flows. An NZ waits for
// the accumulate loop through the adder (the next add needs the previous
// sum), so the adder works on one NZ at a time. An EMPTY item waits until
// the adder has drained and the output register is free.
// An NZ beat with row_last reaches its result beat through the 6 multiplier
// stages, the adder phases and the output register.
// The vector store is a registered-read memory; a read follows every write
// issued by an earlier beat, so no interlock is needed on it.
// Reset clears the row sum to +0, the row counter to zero and all valid
// bits; vector entries hold garbage until loaded.
// When out_stall holds a beat, the output register and the adder keep a row's
// final sum; the multiplier pipeline stops, raising in_stall, once it backs up.
module csr_sparse_matrix_vector_multiply_top #(
  parameter int unsigned     VEC_DEPTH = cspmv_pkg::VEC_DEPTH_DEF,
  parameter longint unsigned MAX_ROWS  = cspmv_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [cspmv_pkg::IDX_W-1:0] in_index,
  input  logic [cspmv_pkg::DW-1:0]    in_value,
  input  logic                        in_row_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cspmv_pkg::ROW_W-1:0] out_row_index,
  output logic [cspmv_pkg::DW-1:0]    out_y_value
);
  import cspmv_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);

  mul_tail_t     tail;
  logic          en;
  logic          add_start, add_ack, add_busy, add_rv, add_free;
  logic [DW-1:0] add_res, add_a;
  logic          out_free, take_empty, last_r;
  logic [DW-1:0] sum_r;
  logic [RW-1:0] cnt_r;
  logic [RW:0]   cnt_inc;
  logic          advance;

  cspmv_mul #(.VEC_DEPTH(VEC_DEPTH)) u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_op      (in_op),
    .in_index   (in_index),
    .in_value   (in_value),
    .in_row_last(in_row_last),
    .tail       (tail)
  );

  assign out_free   = !out_valid || !out_stall;
  assign add_ack    = add_rv && (!last_r || out_free);
  assign add_free   = !add_busy || add_ack;
  assign add_start  = tail.vld && tail.op == OP_NZ && add_free;
  assign take_empty = tail.vld && tail.op == OP_EMPTY && !add_busy && out_free;
  assign en         = !tail.vld || add_start || take_empty;
  assign in_stall   = !en;
  assign add_a      = add_ack ? (last_r ? '0 : add_res) : sum_r;

  cspmv_add u_add (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (add_start),
    .a        (add_a),
    .b        (tail.prod),
    .ack      (add_ack),
    .busy     (add_busy),
    .res_valid(add_rv),
    .res      (add_res)
  );

  assign advance = (add_ack && last_r) || take_empty;
  assign cnt_inc = {1'b0, cnt_r} + (RW + 1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      cnt_r     <= '0;
      last_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (add_ack) begin
        sum_r <= last_r ? '0 : add_res;
      end
      if (add_start) begin
        last_r <= tail.last;
      end
      if (advance) begin
        cnt_r <= (64'(cnt_inc) >= MAX_ROWS) ? '0 : cnt_inc[RW-1:0];
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_row_index <= ROW_W'(cnt_r);
      out_y_value   <= take_empty ? '0 : add_res;
    end
  end

endmodule

>>> bench/csr_sparse_matrix_vector_multiply_top_tb.sv
// Self-checking testbench for csr_sparse_matrix_vector_multiply_top: directed and random
// CSR traffic under random idling and a long output hold, scored against a binary64 predictor.
// Depends on cspmv_pkg and the RTL under rtl/; nothing else.
module csr_sparse_matrix_vector_multiply_top_tb;
  import cspmv_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam logic [63:0] POS_ZERO = 64'h0000_0000_0000_0000;
  localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_INF  = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] ONE      = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] MAX_NORM = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_SUB  = 64'h0000_0000_0000_0001;
  localparam logic [63:0] SNAN     = 64'hFFF0_0000_0000_0001;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [DW-1:0]    y;
  } row_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_op;
  logic [IDX_W-1:0]    in_index;
  logic [DW-1:0]       in_value;
  logic                in_row_last;
  logic                out_valid;
  logic                out_stall;
  logic [ROW_W-1:0]    out_row_index;
  logic [DW-1:0]       out_y_value;

  logic [DW-1:0]       vec_mem [VEC_DEPTH_DEF];
  bit                  vec_loaded [VEC_DEPTH_DEF];
  int unsigned         loaded_idx [$];
  logic [DW-1:0]       row_acc;
  logic [ROW_W-1:0]    row_ctr;
  row_result_t         pending_rows [$];

  int                  err_count;
  int                  cycle_count;
  int                  send_gap_pct;
  int                  stall_pct;
  int                  hold_seq;
  int                  hold_seen;
  int                  hold_left;

  csr_sparse_matrix_vector_multiply_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_index     (in_index),
    .in_value     (in_value),
    .in_row_last  (in_row_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row_index(out_row_index),
    .out_y_value  (out_y_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [DW-1:0] quiet(input logic [DW-1:0] b);
    if ((&b[62:52]) && (|b[51:0])) return CANON_NAN;
    return b;
  endfunction

  task automatic predict_beat(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [DW-1:0] val, input logic last);
    logic [DW-1:0] prod;
    if (op == OP_LOAD) begin
      vec_mem[idx] = val;
      if (!vec_loaded[idx]) loaded_idx.push_back(32'(idx));
      vec_loaded[idx] = 1'b1;
    end else if (op == OP_NZ) begin
      prod = quiet($realtobits($bitstoreal(val) * $bitstoreal(vec_mem[idx])));
      row_acc = quiet($realtobits($bitstoreal(row_acc) + $bitstoreal(prod)));
      if (last) begin
        pending_rows.push_back('{row: row_ctr, y: row_acc});
        row_acc = POS_ZERO;
        row_ctr++;
      end
    end else if (op == OP_EMPTY) begin
      pending_rows.push_back('{row: row_ctr, y: POS_ZERO});
      row_ctr++;
    end
  endtask

  task automatic send_beat(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [DW-1:0] val, input logic last);
    @(negedge clk);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_op       = op;
    in_index    = idx;
    in_value    = val;
    in_row_last = last;
    do @(posedge clk); while (in_stall);
    predict_beat(op, idx, val, last);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] rand_double();
    logic [DW-1:0] b;
    case ($urandom_range(9))
      0:       b = {$urandom, $urandom};
      1:       b = {1'($urandom_range(1)), 11'h0, 20'($urandom_range(3)), $urandom};
      2:       b = {1'($urandom_range(1)), 11'h7FF,
                    $urandom_range(1) ? 52'h0 : {20'h0, $urandom}};
      3:       b = $urandom_range(1) ? NEG_ZERO : POS_ZERO;
      default: b = {1'($urandom_range(1)), 11'($urandom_range(1003, 1043)), 20'($urandom),
                    $urandom};
    endcase
    return b;
  endfunction

  function automatic logic [IDX_W-1:0] pick_loaded();
    return IDX_W'(loaded_idx[$urandom_range(loaded_idx.size() - 1)]);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        $error("unexpected beat: row_index %0d y_value %h", out_row_index, out_y_value);
        err_count++;
      end else begin
        want = pending_rows.pop_front();
        if (out_row_index !== want.row) begin
          $error("row_index: expected %0d, got %0d", want.row, out_row_index);
          err_count++;
        end
        if (out_y_value !== want.y) begin
          $error("y_value: expected %h, got %h", want.y, out_y_value);
          err_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_beat(OP_LOAD, 10'd0, ONE, 1'b1);
    send_beat(OP_LOAD, 10'd1023, MAX_NORM, 1'b0);
    send_beat(OP_LOAD, 10'd1, POS_INF, 1'b0);
    send_beat(OP_LOAD, 10'd2, MIN_SUB, 1'b0);
    send_beat(OP_LOAD, 10'd3, NEG_ZERO, 1'b0);
    send_beat(OP_LOAD, 10'd4, SNAN, 1'b0);
    send_beat(OP_NZ, 10'd0, ONE, 1'b0);
    send_beat(OP_NZ, 10'd1023, MAX_NORM, 1'b1);
    send_beat(OP_NZ, 10'd1, POS_ZERO, 1'b1);
    send_beat(OP_NZ, 10'd3, NEG_ZERO, 1'b1);
    send_beat(OP_NZ, 10'd3, ONE, 1'b1);
    send_beat(OP_NZ, 10'd2, 64'h3FE0_0000_0000_0000, 1'b1);
    send_beat(OP_NZ, 10'd4, ONE, 1'b1);
    send_beat(OP_NZ, 10'd1, NEG_INF, 1'b0);
    send_beat(OP_NZ, 10'd1, ONE, 1'b1);
    send_beat(OP_NZ, 10'd0, 64'h4000_0000_0000_0000, 1'b0);
    send_beat(OP_EMPTY, 10'h3FF, {64{1'b1}}, 1'b1);
    send_beat(OP_UNUSED, 10'h2AA, ONE, 1'b1);
    send_beat(OP_NZ, 10'd0, ONE, 1'b1);
    send_beat(OP_EMPTY, 10'd0, POS_ZERO, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int len;
    sent = 0;
    repeat (8) send_beat(OP_LOAD, 10'($urandom), rand_double(), 1'($urandom));
    while (sent < n_items) begin
      case ($urandom_range(19))
        0, 1, 2: begin
          send_beat(OP_LOAD, 10'($urandom), rand_double(), 1'($urandom));
          sent++;
        end
        3, 4: begin
          send_beat(OP_EMPTY, 10'($urandom), {$urandom, $urandom}, 1'($urandom));
          sent++;
        end
        5: begin
          send_beat(OP_NZ, pick_loaded(), rand_double(), 1'($urandom));
          sent++;
        end
        6:
          send_beat(OP_UNUSED, 10'($urandom), {$urandom, $urandom}, 1'($urandom));
        default: begin
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            send_beat(OP_NZ, pick_loaded(), rand_double(), k == len - 1);
          end
          sent += len;
        end
      endcase
    end
    wait_idle();
  endtask

  task automatic test_fill_and_stall();
    hold_seq++;
    for (int k = 0; k < 60; k++) begin
      send_beat(OP_NZ, pick_loaded(), rand_double(), 1'(k % 2));
    end
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_LOAD;
    in_index = '0;
    in_value = '0;
    in_row_last = 1'b0;
    row_acc = POS_ZERO;
    row_ctr = '0;
    err_count = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    hold_seq = 0;
    hold_seen = 0;
    hold_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    send_gap_pct = 23;
    stall_pct = 81;
    test_random_traffic(400);
    send_gap_pct = 81;
    stall_pct = 23;
    test_random_traffic(400);
    send_gap_pct = 0;
    stall_pct = 0;
    test_random_traffic(400);
    test_fill_and_stall();

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
